// ===== rtl/core/mexp_pkg.sv =====
package mexp_pkg;

  localparam int Width   = 32;
  localparam int CntW    = $clog2(Width);
  localparam int CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgExponent = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgModulus  = CfgIdxW'(1);

  localparam logic [Width-1:0] ExponentReset = Width'(65537);
  localparam logic [Width-1:0] ModulusReset  = '1;

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StStep,
    StMulAcc,
    StMulSqr,
    StFinish
  } state_e;

  typedef struct packed {
    logic             start;
    logic [Width-1:0] x;
    logic [Width-1:0] y;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [Width-1:0] dividend;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [Width-1:0] value;
  } unit_rsp_t;

endpackage

// ===== rtl/core/mexp_if.sv =====
interface mexp_msg_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::Width-1:0] message;

  modport source (output valid, output message, input ready);
  modport sink   (input valid, input message, output ready);
endinterface

interface mexp_res_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::Width-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface mexp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::CfgIdxW-1:0] index;
  logic [mexp_pkg::Width-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mexp_rem.sv =====
module mexp_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mexp_pkg::rem_req_t         req_i,
  input  logic [mexp_pkg::Width-1:0] modulus_i,
  output mexp_pkg::unit_rsp_t        rsp_o
);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [mexp_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [mexp_pkg::Width-1:0] rem_q, rem_d;
  logic [mexp_pkg::Width-1:0] div_q, div_d;
  logic [mexp_pkg::Width:0]   shifted;
  logic                       last;

  assign shifted = {rem_q, div_q[mexp_pkg::Width-1]};
  assign last    = (cnt_q == mexp_pkg::CntW'(mexp_pkg::Width - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = req_i.dividend;
    end else if (busy_q) begin
      div_d = {div_q[mexp_pkg::Width-2:0], 1'b0};
      if (shifted >= {1'b0, modulus_i}) begin
        rem_d = mexp_pkg::Width'(shifted - {1'b0, modulus_i});
      end else begin
        rem_d = shifted[mexp_pkg::Width-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = rem_q;

endmodule

// ===== rtl/core/mexp_mulmod.sv =====
module mexp_mulmod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mexp_pkg::mul_req_t         req_i,
  input  logic [mexp_pkg::Width-1:0] modulus_i,
  output mexp_pkg::unit_rsp_t        rsp_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [mexp_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [mexp_pkg::Width-1:0] acc_q, acc_d;
  logic [mexp_pkg::Width-1:0] x_q, x_d;
  logic [mexp_pkg::Width-1:0] y_q, y_d;
  logic [mexp_pkg::Width:0]   acc_sum;
  logic [mexp_pkg::Width:0]   x_dbl;
  logic [mexp_pkg::Width:0]   mod_ext;
  logic                       last;

  assign mod_ext = {1'b0, modulus_i};
  assign acc_sum = {1'b0, acc_q} + {1'b0, x_q};
  assign x_dbl   = {x_q, 1'b0};
  assign last    = (cnt_q == mexp_pkg::CntW'(mexp_pkg::Width - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      x_d    = req_i.x;
      y_d    = req_i.y;
    end else if (busy_q) begin
      if (y_q[0]) begin
        if (acc_sum >= mod_ext) begin
          acc_d = mexp_pkg::Width'(acc_sum - mod_ext);
        end else begin
          acc_d = acc_sum[mexp_pkg::Width-1:0];
        end
      end
      if (x_dbl >= mod_ext) begin
        x_d = mexp_pkg::Width'(x_dbl - mod_ext);
      end else begin
        x_d = x_dbl[mexp_pkg::Width-1:0];
      end
      y_d   = {1'b0, y_q[mexp_pkg::Width-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = acc_q;

endmodule

// ===== rtl/core/modular_exponentiation_unit.sv =====
// Modular exponentiation: result = message ** exponent mod modulus.
// Channels: msg_i takes one message item, res_o returns one result item,
// cfg_i writes exponent (index 0) or modulus (index 1); other indexes are
// dropped. cfg_i is always ready; write it only while the block is idle.
// One item is worked on at a time; msg_i is ready only while no item is being
// worked on. The message is first reduced by a bit-serial restoring remainder
// unit, then the exponent is scanned from its low bit by a shift-and-add
// modular multiplier, one multiplier bit per cycle. With k the index of the
// top set exponent bit and p its popcount, an item takes k + p multiplies.
// An exponent of zero gives 1 for a modulus of 2 or more; a modulus below 2
// gives 0. msg_i goes ready together with res_o.valid.
// While res_o is stalled its output register holds the item; one more
// message may be taken and worked, but its result waits and msg_i stays low
// until res_o drains.
// Reset restores exponent 65537 and an all-ones modulus and empties the
// block.
module modular_exponentiation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mexp_cfg_if.sink    cfg_i,
  mexp_msg_if.sink    msg_i,
  mexp_res_if.source  res_o
);

  mexp_pkg::state_e           state_q, state_d;
  logic [mexp_pkg::Width-1:0] exponent_q;
  logic [mexp_pkg::Width-1:0] modulus_q;
  logic [mexp_pkg::Width-1:0] acc_q;
  logic [mexp_pkg::Width-1:0] base_q;
  logic [mexp_pkg::Width-1:0] e_q;
  logic [mexp_pkg::Width-1:0] res_q;
  logic                       res_valid_q, res_valid_d;
  logic                       msg_acc;
  logic                       mod_small;
  logic                       out_free;

  mexp_pkg::mul_req_t  mul_req;
  mexp_pkg::unit_rsp_t mul_rsp;
  mexp_pkg::rem_req_t  rem_req;
  mexp_pkg::unit_rsp_t rem_rsp;

  assign cfg_i.ready = 1'b1;
  assign msg_acc     = msg_i.valid && msg_i.ready;
  assign mod_small   = (modulus_q[mexp_pkg::Width-1:1] == '0);
  assign out_free    = !res_valid_q || res_o.ready;

  mexp_rem u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rem_req),
    .modulus_i (modulus_q),
    .rsp_o     (rem_rsp)
  );

  mexp_mulmod u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .modulus_i (modulus_q),
    .rsp_o     (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= mexp_pkg::ExponentReset;
      modulus_q  <= mexp_pkg::ModulusReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        mexp_pkg::CfgExponent: exponent_q <= cfg_i.data;
        mexp_pkg::CfgModulus:  modulus_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mexp_pkg::StIdle: begin
        if (msg_acc) begin
          state_d = mod_small ? mexp_pkg::StFinish : mexp_pkg::StReduce;
        end
      end
      mexp_pkg::StReduce: begin
        if (rem_rsp.done) state_d = mexp_pkg::StStep;
      end
      mexp_pkg::StStep: begin
        if (e_q == '0) begin
          state_d = mexp_pkg::StFinish;
        end else if (e_q[0]) begin
          state_d = mexp_pkg::StMulAcc;
        end else begin
          state_d = mexp_pkg::StMulSqr;
        end
      end
      mexp_pkg::StMulAcc: begin
        if (mul_rsp.done) state_d = mexp_pkg::StStep;
      end
      mexp_pkg::StMulSqr: begin
        if (mul_rsp.done) state_d = mexp_pkg::StStep;
      end
      mexp_pkg::StFinish: begin
        if (out_free) state_d = mexp_pkg::StIdle;
      end
      default: state_d = mexp_pkg::StIdle;
    endcase
  end

  always_comb begin
    msg_i.ready      = (state_q == mexp_pkg::StIdle);
    rem_req.start    = msg_acc && !mod_small;
    rem_req.dividend = msg_i.message;
    mul_req.start    = (state_q == mexp_pkg::StStep) && (e_q != '0);
    mul_req.x        = e_q[0] ? acc_q : base_q;
    mul_req.y        = base_q;
    res_valid_d      = res_valid_q;
    if ((state_q == mexp_pkg::StFinish) && out_free) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::StIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mexp_pkg::StIdle: begin
        if (msg_acc) acc_q <= mod_small ? '0 : mexp_pkg::Width'(1);
      end
      mexp_pkg::StReduce: begin
        if (rem_rsp.done) begin
          base_q <= rem_rsp.value;
          e_q    <= exponent_q;
        end
      end
      mexp_pkg::StMulAcc: begin
        if (mul_rsp.done) begin
          acc_q <= mul_rsp.value;
          e_q   <= {e_q[mexp_pkg::Width-1:1], 1'b0};
        end
      end
      mexp_pkg::StMulSqr: begin
        if (mul_rsp.done) begin
          base_q <= mul_rsp.value;
          e_q    <= {1'b0, e_q[mexp_pkg::Width-1:1]};
        end
      end
      mexp_pkg::StFinish: begin
        if (out_free) res_q <= acc_q;
      end
      default: ;
    endcase
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.result = res_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  typedef logic [mexp_pkg::Width-1:0] word_t;

  localparam logic [mexp_pkg::CfgIdxW-1:0] CfgUnused = mexp_pkg::CfgIdxW'(2);
  localparam logic [mexp_pkg::CfgIdxW-1:0] CfgTop    = '1;
  localparam int unsigned CycleLimit = 2_500_000;
  localparam int unsigned TailCycles = 2200;
  localparam int unsigned HoldCycles = 600;

  logic clk_i;
  logic rst_ni;

  mexp_cfg_if cfg_bus ();
  mexp_msg_if msg_bus ();
  mexp_res_if res_bus ();

  modular_exponentiation_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .msg_i  (msg_bus),
    .res_o  (res_bus)
  );

  word_t       key_exponent;
  word_t       key_modulus;
  word_t       pending_powers[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          idle_off;
  int unsigned hold_go;
  int unsigned hold_len;

  function automatic word_t mod_add(word_t a, word_t b, word_t m);
    logic [mexp_pkg::Width:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[mexp_pkg::Width-1:0];
  endfunction

  function automatic word_t mod_mul(word_t a, word_t b, word_t m);
    word_t acc;
    acc = '0;
    for (int i = 0; i < mexp_pkg::Width; i++) begin
      if (b[i]) begin
        acc = mod_add(acc, a, m);
      end
      a = mod_add(a, a, m);
    end
    return acc;
  endfunction

  function automatic word_t modexp_predict(word_t msg, word_t e, word_t m);
    word_t base;
    word_t acc;
    if (m < 2) begin
      return '0;
    end
    base = msg % m;
    acc  = word_t'(1);
    for (int i = 0; i < mexp_pkg::Width; i++) begin
      if (e[i]) begin
        acc = mod_mul(acc, base, m);
      end
      base = mod_mul(base, base, m);
    end
    return acc;
  endfunction

  function automatic word_t random_exponent();
    word_t e;
    e = $urandom;
    case ($urandom_range(3))
      0: e = e >> $urandom_range(31, 24);
      1: e = e >> $urandom_range(23, 8);
      default: ;
    endcase
    return e;
  endfunction

  function automatic word_t random_modulus();
    word_t m;
    m = $urandom;
    case ($urandom_range(3))
      0: m = m >> $urandom_range(30, 24);
      1: m = m | {1'b1, {(mexp_pkg::Width-1){1'b0}}};
      default: ;
    endcase
    if (m < 2) begin
      m = word_t'(2);
    end
    return m;
  endfunction

  function automatic word_t random_message();
    case ($urandom_range(7))
      0: return '0;
      1: return key_modulus - 1;
      2: return key_modulus;
      3: return key_modulus + word_t'($urandom_range(255));
      4, 5: return word_t'($urandom_range(key_modulus - 1));
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("modular_exponentiation_unit test failed");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_go) begin
        hold_seen = hold_go;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (!idle_off && $urandom_range(99) < 19) begin
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    word_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, res_bus.result);
        mismatch_count++;
      end else begin
        want = pending_powers.pop_front();
        if (res_bus.result !== want) begin
          $display("%0t: result mismatch: expected %h, actual %h", $time, want,
                   res_bus.result);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_message(input word_t msg);
    if (!idle_off && $urandom_range(99) < 19) begin
      msg_bus.valid   <= 1'b0;
      msg_bus.message <= word_t'($urandom);
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
    msg_bus.valid   <= 1'b1;
    msg_bus.message <= msg;
    do @(posedge clk_i); while (!msg_bus.ready);
    pending_powers.push_back(modexp_predict(msg, key_exponent, key_modulus));
  endtask

  // drop valid and hold until every result is back
  task automatic finish_phase();
    msg_bus.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [mexp_pkg::CfgIdxW-1:0] idx,
                                input word_t value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      mexp_pkg::CfgExponent: key_exponent = value;
      mexp_pkg::CfgModulus:  key_modulus  = value;
      default: ;
    endcase
  endtask

  task automatic release_config();
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic load_key(input word_t e, input word_t m);
    write_register(mexp_pkg::CfgExponent, e);
    write_register(mexp_pkg::CfgModulus, m);
    release_config();
  endtask

  task automatic test_reset_values();
    send_message('0);
    send_message(word_t'(1));
    send_message('1);
    send_message('1 - 1);
    send_message({1'b1, {(mexp_pkg::Width-1){1'b0}}});
    finish_phase();
  endtask

  task automatic test_exponent_extremes();
    load_key('0, mexp_pkg::ModulusReset);
    send_message('0);
    send_message('1);
    send_message(word_t'($urandom));
    finish_phase();
    load_key('1, '1);
    send_message('1 - 1);
    send_message(word_t'(2));
    finish_phase();
  endtask

  task automatic test_modulus_extremes();
    load_key('1, word_t'(2));
    send_message('0);
    send_message(word_t'(1));
    send_message(word_t'(2));
    send_message(word_t'(3));
    send_message('1);
    finish_phase();
    load_key(word_t'(1), {1'b1, {(mexp_pkg::Width-1){1'b0}}});
    send_message('1);
    send_message({1'b1, {(mexp_pkg::Width-1){1'b0}}});
    send_message({1'b0, {(mexp_pkg::Width-1){1'b1}}});
    finish_phase();
    // out-of-range moduli give zero
    load_key(mexp_pkg::ExponentReset, '0);
    send_message(word_t'(5));
    finish_phase();
    load_key(mexp_pkg::ExponentReset, word_t'(1));
    send_message(word_t'(5));
    finish_phase();
  endtask

  task automatic test_unknown_index();
    load_key(word_t'(5), word_t'(1000003));
    write_register(CfgUnused, word_t'(7));
    write_register(CfgTop, word_t'(3));
    release_config();
    send_message(word_t'(2));
    send_message('1);
    finish_phase();
  endtask

  task automatic test_random_keys();
    for (int s = 0; s < 9; s++) begin
      load_key(random_exponent(), random_modulus());
      repeat (24) send_message(random_message());
      finish_phase();
    end
  endtask

  task automatic test_backpressure();
    idle_off = 1'b1;
    load_key(word_t'(3), random_modulus());
    hold_len = HoldCycles;
    hold_go++;
    repeat (12) send_message(random_message());
    finish_phase();
    idle_off = 1'b0;
  endtask

  task automatic test_long_burst();
    idle_off = 1'b1;
    load_key(word_t'($urandom_range(255)), random_modulus());
    repeat (30) send_message(random_message());
    finish_phase();
    idle_off = 1'b0;
  endtask

  initial begin
    idle_off        = 1'b0;
    hold_go         = 0;
    hold_len        = 0;
    key_exponent    = mexp_pkg::ExponentReset;
    key_modulus     = mexp_pkg::ModulusReset;
    rst_ni          = 1'b0;
    msg_bus.valid   = 1'b0;
    msg_bus.message = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = '0;
    cfg_bus.data    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_exponent_extremes();
    test_modulus_extremes();
    test_unknown_index();
    test_random_keys();
    test_backpressure();
    test_long_burst();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_powers.size() == 0) begin
      $display("modular_exponentiation_unit test passed");
    end else begin
      $display("modular_exponentiation_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_if.sv
rtl/core/mexp_rem.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_unit.sv
sim/testbench.sv
